// ===== design/balc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balc_pkg
// Shared types, byte codes and lookup functions for the bill acceptor link.
// ----------------------------------------------------------------------------
package balc_pkg;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ESCROW = 2'd1,
        PH_COMMIT = 2'd2
    } phase_t;

    localparam logic [7:0] BYTE_POLL_A   = 8'h80;
    localparam logic [7:0] BYTE_POLL_B   = 8'h8F;
    localparam logic [7:0] BYTE_ESCROW   = 8'h81;
    localparam logic [7:0] BYTE_NOTE_LO  = 8'h40;
    localparam logic [7:0] BYTE_NOTE_HI  = 8'h43;
    localparam logic [7:0] BYTE_STACKED  = 8'h10;
    localparam logic [7:0] BYTE_ACK      = 8'h02;
    localparam logic [7:0] BYTE_REJECT   = 8'h0F;

    localparam int NUM_STATUS  = 20;
    localparam int NUM_NOTES   = 4;
    localparam int COUNT_W     = 16;
    localparam int FARE_W      = 33;
    localparam int TIMER_W     = 16;

    localparam logic [3:0]  RESET_ENABLE  = 4'hF;
    localparam logic [15:0] RESET_TIMEOUT = 16'd2000;

    // APB register map (word addressed by paddr[2])
    localparam logic REG_ENABLE  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic [7:0] STATUS_CODES [NUM_STATUS] = '{
        8'h10, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h27, 8'h28, 8'h29,
        8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h3E, 8'h3F, 8'h80, 8'h8F
    };

    typedef struct packed {
        logic [3:0]  denom_enable;
        logic [15:0] timeout_ms;
    } balc_cfg_t;

    // One-hot match of a byte against the status table; zero when unknown
    function automatic logic [NUM_STATUS-1:0] status_match(input logic [7:0] b);
        logic [NUM_STATUS-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_STATUS; i++) begin
            m[i] = (STATUS_CODES[i] == b);
        end
        return m;
    endfunction

    function automatic logic [FARE_W-1:0] note_value(input logic [1:0] k);
        logic [FARE_W-1:0] v;
        case (k)
            2'd0:    v = FARE_W'(1000);
            2'd1:    v = FARE_W'(5000);
            2'd2:    v = FARE_W'(10000);
            default: v = FARE_W'(50000);
        endcase
        return v;
    endfunction

endpackage

// ===== design/balc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balc_core
// Link state, note counters and one-stage result register.
// ----------------------------------------------------------------------------
module balc_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  balc_pkg::balc_cfg_t              cfg,
    input  logic                             item_valid,
    input  balc_pkg::op_t                    item_op,
    input  logic [7:0]                       item_byte,
    output logic                             item_stall,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             tx_valid,
    output logic [7:0]                       tx_byte,
    output logic [balc_pkg::NUM_STATUS-1:0]  status_bits,
    output logic [balc_pkg::COUNT_W-1:0]     count_1k,
    output logic [balc_pkg::COUNT_W-1:0]     count_5k,
    output logic [balc_pkg::COUNT_W-1:0]     count_10k,
    output logic [balc_pkg::COUNT_W-1:0]     count_50k,
    output logic [balc_pkg::FARE_W-1:0]      total_fare,
    output logic                             exchange_done,
    output logic                             timed_out,
    output logic                             unknown_byte
);
    import balc_pkg::*;

    phase_t                phase_reg,   phase_next;
    logic [1:0]            pending_reg, pending_next;
    logic [COUNT_W-1:0]    notes_reg [NUM_NOTES];
    logic [COUNT_W-1:0]    notes_next [NUM_NOTES];
    logic [FARE_W-1:0]     fare_reg,    fare_next;
    logic [NUM_STATUS-1:0] flags_reg,   flags_next;
    logic [TIMER_W-1:0]    timer_reg,   timer_next;

    logic       res_valid_reg;
    logic       tx_valid_reg,  tx_valid_next;
    logic [7:0] tx_byte_reg,   tx_byte_next;
    logic       done_reg,      done_next;
    logic       tmo_reg,       tmo_next;
    logic       unk_reg,       unk_next;

    logic                  advance;
    logic                  load;
    logic [NUM_STATUS-1:0] match;
    logic [TIMER_W-1:0]    timer_inc;
    logic [1:0]            note_idx;
    logic                  note_ok;
    logic [COUNT_W-1:0]    cur_count;

    assign advance    = !res_valid_reg || !out_stall;
    assign load       = item_valid && advance;
    assign item_stall = !advance;

    assign match     = status_match(item_byte);
    assign timer_inc = (timer_reg != {TIMER_W{1'b1}}) ? timer_reg + 1'b1 : timer_reg;
    assign note_idx  = item_byte[1:0];
    assign note_ok   = (item_byte >= BYTE_NOTE_LO) && (item_byte <= BYTE_NOTE_HI)
                       && cfg.denom_enable[note_idx];
    assign cur_count = notes_reg[pending_reg];

    always_comb
    begin
        phase_next    = phase_reg;
        pending_next  = pending_reg;
        notes_next    = notes_reg;
        fare_next     = fare_reg;
        flags_next    = flags_reg;
        timer_next    = timer_reg;
        tx_valid_next = 1'b0;
        tx_byte_next  = 8'h00;
        done_next     = 1'b0;
        tmo_next      = 1'b0;
        unk_next      = 1'b0;
        case (item_op)
            OP_BYTE:
            begin
                timer_next = '0;
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (item_byte == BYTE_POLL_A || item_byte == BYTE_POLL_B) begin
                            tx_valid_next = 1'b1;
                            tx_byte_next  = BYTE_ACK;
                            done_next     = 1'b1;
                        end else if (item_byte == BYTE_ESCROW) begin
                            phase_next = PH_ESCROW;
                        end else if (match != '0) begin
                            flags_next = flags_reg | match;
                        end else begin
                            unk_next = 1'b1;
                        end
                    end
                    PH_ESCROW:
                    begin
                        tx_valid_next = 1'b1;
                        if (note_ok) begin
                            pending_next = note_idx;
                            phase_next   = PH_COMMIT;
                            tx_byte_next = BYTE_ACK;
                        end else begin
                            tx_byte_next = BYTE_REJECT;
                        end
                    end
                    default:
                    begin
                        if (item_byte == BYTE_STACKED) begin
                            // saturated count leaves the weighted total unchanged
                            if (cur_count != {COUNT_W{1'b1}}) begin
                                notes_next[pending_reg] = cur_count + 1'b1;
                                fare_next = fare_reg + note_value(pending_reg);
                            end
                            phase_next   = PH_IDLE;
                            pending_next = '0;
                            done_next    = 1'b1;
                        end
                    end
                endcase
            end
            OP_TICK:
            begin
                timer_next = timer_inc;
                if (phase_reg != PH_IDLE && timer_inc >= cfg.timeout_ms) begin
                    phase_next   = PH_IDLE;
                    pending_next = '0;
                    timer_next   = '0;
                    tmo_next     = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NUM_NOTES; i++) begin
                    notes_next[i] = '0;
                end
                fare_next = '0;
            end
            default:
            begin
                timer_next = timer_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            pending_reg   <= '0;
            fare_reg      <= '0;
            flags_reg     <= '0;
            timer_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_NOTES; i++) begin
                notes_reg[i] <= '0;
            end
        end else begin
            if (advance) begin
                res_valid_reg <= item_valid;
            end
            if (load) begin
                phase_reg   <= phase_next;
                pending_reg <= pending_next;
                notes_reg   <= notes_next;
                fare_reg    <= fare_next;
                flags_reg   <= flags_next;
                timer_reg   <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg  <= tx_byte_next;
            done_reg     <= done_next;
            tmo_reg      <= tmo_next;
            unk_reg      <= unk_next;
        end
    end

    assign out_valid     = res_valid_reg;
    assign tx_valid      = tx_valid_reg;
    assign tx_byte       = tx_byte_reg;
    assign exchange_done = done_reg;
    assign timed_out     = tmo_reg;
    assign unknown_byte  = unk_reg;
    assign status_bits   = flags_reg;
    assign count_1k      = notes_reg[0];
    assign count_5k      = notes_reg[1];
    assign count_10k     = notes_reg[2];
    assign count_50k     = notes_reg[3];
    assign total_fare    = fare_reg;

    a_timeout_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load && tmo_next |=> phase_reg == PH_IDLE && pending_reg == '0)
        else $error("timeout did not return link to idle");

    a_pending_only_commit: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != '0 |-> phase_reg == PH_COMMIT)
        else $error("pending note held outside commit phase");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        load && item_op == OP_CLEAR |=> fare_reg == '0 && notes_reg[0] == '0
        && notes_reg[3] == '0)
        else $error("clear totals left nonzero counts");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        load && item_op != OP_CLEAR |=> fare_reg >= $past(fare_reg))
        else $error("total decreased without clear");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && out_stall |=> $stable(flags_reg) && $stable(fare_reg))
        else $error("state moved while result was stalled");

endmodule

// ===== design/bill_acceptor_link_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bill_acceptor_link_controller
// Host side of a banknote acceptor byte exchange with APB configuration.
// ----------------------------------------------------------------------------
// Path: an accepted request lands in the input register, and the link
//   update then loads its result into the result register.
// Throughput: one request per cycle; the only hold-off is a stalled result.
// Reset: rst_n clears phase, counts, total, flags, timer and both valid bits;
//   denomination_enable returns to 0xF and timeout_ms to 2000.
// Counts, total and status bits on the result reflect state after the request.
// ----------------------------------------------------------------------------
module bill_acceptor_link_controller
(
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       opcode,
    input  logic [7:0]                       rx_byte,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             tx_valid,
    output logic [7:0]                       tx_byte,
    output logic [balc_pkg::NUM_STATUS-1:0]  status_bits,
    output logic [balc_pkg::COUNT_W-1:0]     count_1k,
    output logic [balc_pkg::COUNT_W-1:0]     count_5k,
    output logic [balc_pkg::COUNT_W-1:0]     count_10k,
    output logic [balc_pkg::COUNT_W-1:0]     count_50k,
    output logic [balc_pkg::FARE_W-1:0]      total_fare,
    output logic                             exchange_done,
    output logic                             timed_out,
    output logic                             unknown_byte
);
    import balc_pkg::*;

    balc_cfg_t  cfg_reg;
    logic       cfg_write;

    logic       s1_valid_reg;
    op_t        s1_op_reg;
    logic [7:0] s1_byte_reg;
    logic       core_stall;

    // APB: zero wait states, register picked by the word address bit
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.denom_enable <= RESET_ENABLE;
            cfg_reg.timeout_ms   <= RESET_TIMEOUT;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_ENABLE:  cfg_reg.denom_enable <= pwdata[3:0];
                REG_TIMEOUT: cfg_reg.timeout_ms   <= pwdata[15:0];
                default:     cfg_reg.denom_enable <= cfg_reg.denom_enable;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ENABLE:  prdata = {28'd0, cfg_reg.denom_enable};
            REG_TIMEOUT: prdata = {16'd0, cfg_reg.timeout_ms};
            default:     prdata = 32'd0;
        endcase
    end

    // Input register: hold the request while the core cannot take it,
    // otherwise refill every cycle so back-to-back requests flow through.
    assign in_stall = s1_valid_reg && core_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            s1_op_reg   <= op_t'(opcode);
            s1_byte_reg <= rx_byte;
        end
    end

    // Link state update and result register
    balc_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (s1_valid_reg),
        .item_op       (s1_op_reg),
        .item_byte     (s1_byte_reg),
        .item_stall    (core_stall),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .status_bits   (status_bits),
        .count_1k      (count_1k),
        .count_5k      (count_5k),
        .count_10k     (count_10k),
        .count_50k     (count_50k),
        .total_fare    (total_fare),
        .exchange_done (exchange_done),
        .timed_out     (timed_out),
        .unknown_byte  (unknown_byte)
    );

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && core_stall |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("input register dropped a held request");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled while result path was free");

    a_cfg_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> cfg_reg.timeout_ms == RESET_TIMEOUT)
        else $error("timeout register not at reset value");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bill acceptor link controller.
// A queue-fed driver offers requests (bytes, ticks, clear events) with random
// gaps. A monitor predicts each result from its own copy of the link state
// and compares every field of the result stream. Several register settings
// are visited through the APB port, each written only while the link is
// drained.
// ----------------------------------------------------------------------------
module tb;
    import balc_pkg::*;

    localparam int NUM_SETTINGS      = 7;
    localparam int ITEMS_PER_SETTING = 133;
    localparam int DRAIN_CYCLES      = 6;     // two-stage pipe plus margin
    localparam int HOLD_CYCLES       = 64;    // long receiver hold-off
    localparam int HOLD_SPACING      = 311;   // results between hold-offs
    localparam int QUIET_LIMIT       = 1000;  // cycles with no transfer at all
    localparam int MAX_PRINTS        = 50;

    localparam logic [3:0]  SET_ENABLE  [NUM_SETTINGS] =
        '{4'hF, 4'h0, 4'h5, 4'hA, 4'hF, 4'h0, 4'hF};
    localparam logic [15:0] SET_TIMEOUT [NUM_SETTINGS] =
        '{16'd2000, 16'd1, 16'd3, 16'hFFFF, 16'd4, 16'd0, 16'd2};

    // won per note kind: 1000, 5000, 10000, 50000
    localparam logic [FARE_W-1:0] NOTE_WON [NUM_NOTES] =
        '{33'd1000, 33'd5000, 33'd10000, 33'd50000};

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic                  tx_valid;
        logic [7:0]            tx_byte;
        logic [NUM_STATUS-1:0] status;
        logic [COUNT_W-1:0]    c1k;
        logic [COUNT_W-1:0]    c5k;
        logic [COUNT_W-1:0]    c10k;
        logic [COUNT_W-1:0]    c50k;
        logic [FARE_W-1:0]     fare;
        logic                  done;
        logic                  tmo;
        logic                  unknown;
    } link_result_t;

    // ------------------------------------------------------------------
    // DUT connections; every input is known from time zero
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [2:0]            paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [1:0]            opcode    = OP_BYTE;
    logic [7:0]            rx_byte   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  tx_valid;
    logic [7:0]            tx_byte;
    logic [NUM_STATUS-1:0] status_bits;
    logic [COUNT_W-1:0]    count_1k;
    logic [COUNT_W-1:0]    count_5k;
    logic [COUNT_W-1:0]    count_10k;
    logic [COUNT_W-1:0]    count_50k;
    logic [FARE_W-1:0]     total_fare;
    logic                  exchange_done;
    logic                  timed_out;
    logic                  unknown_byte;

    bill_acceptor_link_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .status_bits   (status_bits),
        .count_1k      (count_1k),
        .count_5k      (count_5k),
        .count_10k     (count_10k),
        .count_50k     (count_50k),
        .total_fare    (total_fare),
        .exchange_done (exchange_done),
        .timed_out     (timed_out),
        .unknown_byte  (unknown_byte)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    req_t         req_backlog[$];    // requests not yet offered
    link_result_t link_outcomes[$];  // predicted results, oldest first

    logic req_fire = 1'b0;           // request taken at the last rising edge
    int   reqs_queued   = 0;
    int   reqs_taken    = 0;
    int   results_seen  = 0;
    int   phase_items   = 0;
    int   errors        = 0;
    int   notes_stacked = 0;
    int   rejects_seen  = 0;
    int   timeouts_seen = 0;
    int   long_holds    = 0;
    int   settings_used = 1;

    // Predicted link state and register copies
    phase_t                lk_phase;
    logic [1:0]            lk_note;
    logic [COUNT_W-1:0]    lk_counts [NUM_NOTES];
    logic [FARE_W-1:0]     lk_fare;
    logic [NUM_STATUS-1:0] lk_flags;
    logic [TIMER_W-1:0]    lk_timer;
    logic [3:0]            lk_enable;
    logic [15:0]           lk_timeout;

    initial begin
        lk_phase   = PH_IDLE;
        lk_note    = '0;
        lk_fare    = '0;
        lk_flags   = '0;
        lk_timer   = '0;
        lk_enable  = RESET_ENABLE;
        lk_timeout = RESET_TIMEOUT;
        for (int k = 0; k < NUM_NOTES; k++) lk_counts[k] = '0;
    end

    // ------------------------------------------------------------------
    // Link prediction: apply one request to the local state and return the
    // result the block must show; outputs reflect state after the request
    // ------------------------------------------------------------------
    function automatic link_result_t advance_link(input req_t r);
        link_result_t res;
        int           hit;
        res = '0;
        hit = -1;
        case (r.op)
            OP_BYTE: begin
                lk_timer = '0;
                if (lk_phase == PH_IDLE) begin
                    // polls answer at once and close the exchange, no flag
                    if (r.data == BYTE_POLL_A || r.data == BYTE_POLL_B) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = BYTE_ACK;
                        res.done     = 1'b1;
                    end else if (r.data == BYTE_ESCROW) begin
                        lk_phase = PH_ESCROW;
                    end else begin
                        for (int i = 0; i < NUM_STATUS; i++) begin
                            if (hit < 0 && STATUS_CODES[i] == r.data) hit = i;
                        end
                        if (hit >= 0) lk_flags[hit] = 1'b1;
                        else          res.unknown   = 1'b1;
                    end
                end else if (lk_phase == PH_ESCROW) begin
                    // every escrow byte gets a reply: accept only enabled notes
                    res.tx_valid = 1'b1;
                    if (r.data >= BYTE_NOTE_LO && r.data <= BYTE_NOTE_HI
                        && lk_enable[r.data[1:0]]) begin
                        lk_note     = r.data[1:0];
                        lk_phase    = PH_COMMIT;
                        res.tx_byte = BYTE_ACK;
                    end else begin
                        res.tx_byte = BYTE_REJECT;
                    end
                end else if (r.data == BYTE_STACKED) begin
                    // stacked: count the note (saturating) and rebuild the total
                    if (lk_counts[lk_note] != '1) lk_counts[lk_note]++;
                    lk_fare = '0;
                    for (int k = 0; k < NUM_NOTES; k++)
                        lk_fare = lk_fare + NOTE_WON[k] * lk_counts[k];
                    lk_phase = PH_IDLE;
                    lk_note  = '0;
                    res.done = 1'b1;
                end
            end
            OP_TICK: begin
                if (lk_timer != '1) lk_timer++;
                if (lk_phase != PH_IDLE && lk_timer >= lk_timeout) begin
                    lk_phase = PH_IDLE;
                    lk_note  = '0;
                    lk_timer = '0;
                    res.tmo  = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int k = 0; k < NUM_NOTES; k++) lk_counts[k] = '0;
                lk_fare = '0;
            end
            default: ;
        endcase
        res.status = lk_flags;
        res.c1k    = lk_counts[0];
        res.c5k    = lk_counts[1];
        res.c10k   = lk_counts[2];
        res.c50k   = lk_counts[3];
        res.fare   = lk_fare;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at result %0d: %s got %0h want %0h",
                     results_seen, what, got, want);
    endtask

    task automatic compare_result(input link_result_t got, input link_result_t want);
        if (got.tx_valid !== want.tx_valid) report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
        if (got.tx_byte  !== want.tx_byte)  report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
        if (got.status   !== want.status)   report_mismatch("status_bits", got.status, want.status);
        if (got.c1k      !== want.c1k)      report_mismatch("count_1k", got.c1k, want.c1k);
        if (got.c5k      !== want.c5k)      report_mismatch("count_5k", got.c5k, want.c5k);
        if (got.c10k     !== want.c10k)     report_mismatch("count_10k", got.c10k, want.c10k);
        if (got.c50k     !== want.c50k)     report_mismatch("count_50k", got.c50k, want.c50k);
        if (got.fare     !== want.fare)     report_mismatch("total_fare", got.fare, want.fare);
        if (got.done     !== want.done)     report_mismatch("exchange_done", got.done, want.done);
        if (got.tmo      !== want.tmo)      report_mismatch("timed_out", got.tmo, want.tmo);
        if (got.unknown  !== want.unknown)  report_mismatch("unknown_byte", got.unknown, want.unknown);
    endtask

    // ------------------------------------------------------------------
    // Gap pattern shared by both sides: each burst is at random either calm (no
    // gaps) or mixed, with mostly no or short gaps and sometimes long ones. Side 0 is the
    // request driver, side 1 the result receiver.
    // ------------------------------------------------------------------
    int burst_left [2] = '{0, 0};
    bit burst_calm [2] = '{1'b0, 1'b0};

    function automatic int next_gap(input int side);
        int r;
        if (burst_left[side] == 0) begin
            burst_left[side] = $urandom_range(20, 80);
            burst_calm[side] = ($urandom_range(0, 99) < 30);
        end
        burst_left[side]--;
        r = $urandom_range(0, 99);
        if (burst_calm[side] || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: change inputs at the falling edge, hold the request
    // until it is taken, then pause for a random gap
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(negedge clk) begin : req_driver
        req_t nxt;
        if (rst_n && (!in_valid || req_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
                nxt = req_backlog.pop_front();
                in_valid <= 1'b1;
                opcode   <= nxt.op;
                rx_byte  <= nxt.data;
                send_gap = next_gap(0);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts, plus a long hold-off every few
    // hundred results so the pipe fills and the block stalls its input
    // ------------------------------------------------------------------
    int stall_left   = 0;
    int hold_left    = 0;
    int next_hold_at = 150;

    always @(negedge clk) begin : res_receiver
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (results_seen >= next_hold_at) begin
                hold_left    = HOLD_CYCLES - 1;
                next_hold_at = next_hold_at + HOLD_SPACING;
                long_holds++;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                stall_left = next_gap(1);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge; predict on every
    // taken request, check every taken result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin : link_monitor
        link_result_t got;
        link_result_t want;
        if (rst_n) begin
            req_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                want = advance_link(req_t'{op: op_t'(opcode), data: rx_byte});
                link_outcomes.push_back(want);
                reqs_taken++;
                if (want.tmo) timeouts_seen++;
                if (want.tx_valid && want.tx_byte == BYTE_REJECT) rejects_seen++;
                if (want.done && opcode == OP_BYTE && rx_byte == BYTE_STACKED)
                    notes_stacked++;
            end
            if (out_valid && !out_stall) begin
                got = '{tx_valid, tx_byte, status_bits, count_1k, count_5k, count_10k,
                        count_50k, total_fare, exchange_done, timed_out, unknown_byte};
                results_seen++;
                if (link_outcomes.size() == 0)
                    report_mismatch("result with nothing predicted", got.fare, 0);
                else
                    compare_result(got, link_outcomes.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves on either channel for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results still awaited",
                 QUIET_LIMIT, link_outcomes.size());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(input op_t op, input logic [7:0] data);
        req_backlog.push_back(req_t'{op: op, data: data});
        reqs_queued++;
        if (op != OP_NONE) phase_items++;
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_req(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write both registers, read each back, then update the predicted copy
    task automatic set_config(input logic [3:0] en, input logic [15:0] tmo);
        logic [31:0] rd;
        apb_access(1'b1, {REG_ENABLE, 2'b00}, {28'd0, en}, rd);
        apb_access(1'b0, {REG_ENABLE, 2'b00}, '0, rd);
        if (rd !== {28'd0, en}) report_mismatch("denomination_enable readback", rd, en);
        apb_access(1'b1, {REG_TIMEOUT, 2'b00}, {16'd0, tmo}, rd);
        apb_access(1'b0, {REG_TIMEOUT, 2'b00}, '0, rd);
        if (rd !== {16'd0, tmo}) report_mismatch("timeout_ms readback", rd, tmo);
        lk_enable  = en;
        lk_timeout = tmo;
        settings_used++;
    endtask

    // Wait until every request is taken and every result checked, then let
    // the pipe settle before touching the registers
    task automatic wait_drained();
        while (!(reqs_taken == reqs_queued && link_outcomes.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One random sequence: mostly full note exchanges and polls with random
    // content, the rest status codes, stray bytes, ticks, clears and unused or random ops
    task automatic add_random_sequence();
        int  r;
        int  tick_len;
        bit  short_tmo;
        short_tmo = (lk_timeout <= 16'd12);
        tick_len  = short_tmo ? int'(lk_timeout) : 2;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            push_req(OP_BYTE, BYTE_ESCROW);
            // up to two random escrow bytes, which usually draw rejects
            repeat ($urandom_range(0, 2)) push_req(OP_BYTE, 8'($urandom_range(0, 255)));
            push_req(OP_BYTE, BYTE_NOTE_LO + 8'($urandom_range(0, 3)));
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0) push_ticks($urandom_range(1, 2));
                else push_req(OP_BYTE, 8'($urandom_range(0, 255)));
            end
            // usually stack the note; otherwise send ticks, which time out the exchange when the timeout is short
            if ($urandom_range(0, 9) < 8) push_req(OP_BYTE, BYTE_STACKED);
            else push_ticks(tick_len);
        end else if (r < 52) begin
            push_req(OP_BYTE, $urandom_range(0, 1) ? BYTE_POLL_A : BYTE_POLL_B);
        end else if (r < 64) begin
            push_req(OP_BYTE, STATUS_CODES[$urandom_range(0, NUM_STATUS - 1)]);
        end else if (r < 74) begin
            push_req(OP_BYTE, 8'($urandom_range(0, 255)));
        end else if (r < 84) begin
            push_ticks($urandom_range(1, short_tmo ? tick_len + 1 : 4));
        end else if (r < 89) begin
            push_req(OP_CLEAR, 8'($urandom_range(0, 255)));
        end else if (r < 93) begin
            push_req(OP_NONE, 8'($urandom_range(0, 255)));
        end else begin
            push_req(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, then one batch of requests per register setting
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [3:0]  en;
        logic [15:0] tmo;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s > 0) begin
                en  = (s == 5) ? 4'($urandom_range(0, 15)) : SET_ENABLE[s];
                tmo = (s == 5) ? 16'($urandom_range(1, 12)) : SET_TIMEOUT[s];
                set_config(en, tmo);
            end
            phase_items = 0;

            if (s == 0) begin
                // reset settings: byte extremes, polls, status codes, two full exchanges
                // (one with a reject and an ignored byte), ticks, clear, unused op
                push_req(OP_BYTE,  8'h00);
                push_req(OP_BYTE,  8'hFF);
                push_req(OP_BYTE,  BYTE_POLL_A);
                push_req(OP_BYTE,  BYTE_POLL_B);
                push_req(OP_BYTE,  BYTE_STACKED);
                push_req(OP_BYTE,  8'h3F);
                push_req(OP_BYTE,  BYTE_ESCROW);
                push_req(OP_BYTE,  8'h44);
                push_req(OP_BYTE,  BYTE_NOTE_HI);
                push_req(OP_BYTE,  8'h55);
                push_req(OP_BYTE,  BYTE_STACKED);
                push_req(OP_BYTE,  BYTE_ESCROW);
                push_req(OP_BYTE,  BYTE_NOTE_LO);
                push_ticks(1);
                push_req(OP_BYTE,  BYTE_STACKED);
                push_req(OP_CLEAR, 8'h00);
                push_req(OP_NONE,  8'hA5);
                push_ticks(1);
            end else if (s == 1) begin
                // all notes disabled, one-tick timeout: rejects, then abandon
                push_req(OP_BYTE, BYTE_ESCROW);
                push_req(OP_BYTE, BYTE_NOTE_LO + 8'd1);
                push_req(OP_BYTE, BYTE_NOTE_HI);
                push_ticks(2);
            end

            while (phase_items < ITEMS_PER_SETTING) add_random_sequence();
            wait_drained();
        end

        $display("run covered %0d requests under %0d register settings; %0d results checked",
                 reqs_taken, settings_used, results_seen);
        $display("notes stacked %0d, rejects %0d, timeouts %0d, long output holds %0d",
                 notes_stacked, rejects_seen, timeouts_seen, long_holds);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
